// ===== sv/tra_pkg.sv =====
// ----------------------------------------------------------------------------
// tra_pkg
// shared types and constants of the task region allocator
// ----------------------------------------------------------------------------
package tra_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_BAD_SIZE = 2'd2;
    localparam status_t STATUS_NO_ROOM  = 2'd3;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_SMALL_BASE  = 2'd0;
    localparam reg_index_t REG_LARGE_BASE  = 2'd1;
    localparam reg_index_t REG_HEAP_END    = 2'd2;
    localparam reg_index_t REG_MAX_REQUEST = 2'd3;

    localparam logic [31:0] SMALL_BASE_RST  = 32'h2000_1000;
    localparam logic [31:0] LARGE_BASE_RST  = 32'h2000_2000;
    localparam logic [31:0] HEAP_END_RST    = 32'h2000_8000;
    localparam logic [15:0] MAX_REQUEST_RST = 16'd24576;

    localparam logic [15:0] SMALL_SIZE = 16'd512;
    localparam logic [15:0] LARGE_UNIT = 16'd1024;
    localparam logic [16:0] LARGE_MASK = 17'd1023;

endpackage

// ===== sv/task_region_allocator.sv =====
// ----------------------------------------------------------------------------
// task_region_allocator
// first-fit region allocator with a slot table scanned by one compare unit
// ----------------------------------------------------------------------------
// sequence: find scans up to the first free slot (a full table or bad size
//   ends there), the overlap pass walks every slot (restarting once on a
//   promotion), then the heap check; done strobes in the same cycle busy drops
// throughput: one request at a time, next one taken at the end of the done
//   cycle; the receiver cannot stall results
// reset: table reads as empty at once (per-slot valid flops), registers default
module task_region_allocator #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [15:0]           request_size,
    output logic                  done,
    output logic [31:0]           region_address,
    output logic [15:0]           granted_size,
    output logic [5:0]            slot_index,
    output tra_pkg::status_t      status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import tra_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_PASS,
        S_STORE
    } state_t;

    // configuration registers
    logic [31:0] small_base_reg;
    logic [31:0] large_base_reg;
    logic [31:0] heap_end_reg;
    logic [15:0] max_request_reg;

    logic        cfg_write;
    reg_index_t  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_base_reg  <= SMALL_BASE_RST;
            large_base_reg  <= LARGE_BASE_RST;
            heap_end_reg    <= HEAP_END_RST;
            max_request_reg <= MAX_REQUEST_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SMALL_BASE:  small_base_reg  <= pwdata;
                REG_LARGE_BASE:  large_base_reg  <= pwdata;
                REG_HEAP_END:    heap_end_reg    <= pwdata;
                REG_MAX_REQUEST: max_request_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SMALL_BASE:  prdata = small_base_reg;
            REG_LARGE_BASE:  prdata = large_base_reg;
            REG_HEAP_END:    prdata = heap_end_reg;
            REG_MAX_REQUEST: prdata = {16'd0, max_request_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // slot table
    logic [31:0] base_mem [SLOT_COUNT];
    logic [15:0] size_mem [SLOT_COUNT];
    logic [31:0] rd_base_reg;
    logic [15:0] rd_size_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    // sequencer state
    state_t         state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [15:0]    req_reg;
    logic [15:0]    size_reg, size_next;
    logic [32:0]    cand_reg, cand_next;
    logic           done_reg, done_next;
    logic [31:0]    addr_reg, addr_next;
    logic [15:0]    gsize_reg, gsize_next;
    logic [5:0]     slot_out_reg, slot_out_next;
    status_t        status_reg, status_next;
    logic           table_write;

    // shared compare unit
    logic [31:0] entry_base;
    logic [15:0] entry_size;
    logic [32:0] entry_hi;
    logic [33:0] cand_end;
    logic        overlap;
    logic [16:0] round_sum;
    logic [16:0] rounded;

    assign entry_base = valid_reg[idx_reg] ? rd_base_reg : 32'd0;
    assign entry_size = valid_reg[idx_reg] ? rd_size_reg : 16'd0;
    assign entry_hi   = {1'b0, entry_base} + {17'd0, entry_size};
    assign cand_end   = {1'b0, cand_reg} + {18'd0, size_reg};
    assign overlap    = (({1'b0, entry_base} <= cand_reg) && (cand_reg < entry_hi))
                     || (({2'b0, entry_base} <= cand_end) && (cand_end < {1'b0, entry_hi}));
    assign round_sum  = {1'b0, req_reg} + LARGE_MASK;
    assign rounded    = round_sum & ~LARGE_MASK;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        size_next     = size_reg;
        cand_next     = cand_reg;
        done_next     = 1'b0;
        addr_next     = addr_reg;
        gsize_next    = gsize_reg;
        slot_out_next = slot_out_reg;
        status_next   = status_reg;
        table_write   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (entry_base == 32'd0)
                begin
                    slot_next = idx_reg;
                    idx_next  = '0;
                    if ((req_reg == 16'd0) || (req_reg > max_request_reg))
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        addr_next = 32'd0; gsize_next = 16'd0; slot_out_next = 6'd0;
                        status_next = STATUS_BAD_SIZE;
                    end
                    else if (req_reg <= SMALL_SIZE)
                    begin
                        size_next  = SMALL_SIZE;
                        cand_next  = {1'b0, small_base_reg};
                        state_next = S_PASS;
                    end
                    else if (rounded[16])
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        addr_next = 32'd0; gsize_next = 16'd0; slot_out_next = 6'd0;
                        status_next = STATUS_BAD_SIZE;
                    end
                    else
                    begin
                        size_next  = rounded[15:0];
                        cand_next  = {1'b0, large_base_reg};
                        state_next = S_PASS;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    addr_next = 32'd0; gsize_next = 16'd0; slot_out_next = 6'd0;
                    status_next = STATUS_FULL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PASS:
            begin
                if (overlap && (size_reg == SMALL_SIZE)
                    && (entry_hi == {1'b0, large_base_reg}))
                begin
                    // promote to a large region and rescan
                    size_next = LARGE_UNIT;
                    cand_next = {1'b0, large_base_reg};
                    idx_next  = '0;
                end
                else
                begin
                    if (overlap)
                    begin
                        cand_next = entry_hi;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = S_STORE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_STORE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (cand_end <= {2'b0, heap_end_reg})
                begin
                    table_write   = 1'b1;
                    addr_next     = cand_reg[31:0];
                    gsize_next    = size_reg;
                    slot_out_next = 6'(slot_reg);
                    status_next   = STATUS_OK;
                end
                else
                begin
                    addr_next = 32'd0; gsize_next = 16'd0; slot_out_next = 6'd0;
                    status_next = STATUS_NO_ROOM;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (table_write)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            req_reg <= request_size;
        end
        slot_reg     <= slot_next;
        size_reg     <= size_next;
        cand_reg     <= cand_next;
        addr_reg     <= addr_next;
        gsize_reg    <= gsize_next;
        slot_out_reg <= slot_out_next;
        status_reg   <= status_next;
    end

    // table memory, read address follows the scan index
    always_ff @(posedge clk)
    begin
        if (table_write)
        begin
            base_mem[slot_reg] <= cand_reg[31:0];
            size_mem[slot_reg] <= size_reg;
        end
        rd_base_reg <= base_mem[idx_next];
        rd_size_reg <= size_mem[idx_next];
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign region_address = addr_reg;
    assign granted_size   = gsize_reg;
    assign slot_index     = slot_out_reg;
    assign status         = status_reg;

    // checks
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_busy_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request dropped without a result");

    a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |->
            ((region_address == 32'd0) && (granted_size == 16'd0) && (slot_index == 6'd0)))
        else $error("failed request returned nonzero fields");

    a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_OK)) |->
            ((granted_size == SMALL_SIZE) || ((granted_size[9:0] == 10'd0)
             && (granted_size != 16'd0))))
        else $error("granted size not 512 or a multiple of 1024");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the task region allocator: a short table of
// directed requests, then phases of random requests under changing region
// registers, each grant checked against its table entry or a first-fit placement predictor
// ----------------------------------------------------------------------------
module tb;

    import tra_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int PHASES      = 20;
    localparam int PHASE_ITEMS = 95;
    localparam int PROBE_COUNT = 12;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] bytes;
        logic [5:0]  slot;
        status_t     code;
    } grant_t;

    typedef struct packed {
        logic [15:0] req;
        logic        typed;
        grant_t      want;
    } probe_t;

    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{16'd0,     1'b1, '{32'd0, 16'd0, 6'd0, STATUS_BAD_SIZE}},
        '{16'd24577, 1'b1, '{32'd0, 16'd0, 6'd0, STATUS_BAD_SIZE}},
        '{16'd65535, 1'b1, '{32'd0, 16'd0, 6'd0, STATUS_BAD_SIZE}},
        '{16'h8000,  1'b1, '{32'd0, 16'd0, 6'd0, STATUS_BAD_SIZE}},
        '{16'd1,     1'b1, '{32'h2000_1000, 16'd512, 6'd0, STATUS_OK}},
        '{16'd512,   1'b1, '{32'h2000_1200, 16'd512, 6'd1, STATUS_OK}},
        '{16'd513,   1'b1, '{32'h2000_2000, 16'd1024, 6'd2, STATUS_OK}},
        '{16'd24576, 1'b0, '0},
        '{16'd1024,  1'b0, '0},
        '{16'd1025,  1'b0, '0},
        '{16'd23553, 1'b0, '0},
        '{16'd24575, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] request_size = '0;
    logic        done;
    logic [31:0] region_address;
    logic [15:0] granted_size;
    logic [5:0]  slot_index;
    status_t     status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] cfg_small_base = SMALL_BASE_RST;
    logic [31:0] cfg_large_base = LARGE_BASE_RST;
    logic [31:0] cfg_heap_end   = HEAP_END_RST;
    logic [15:0] cfg_max_request = MAX_REQUEST_RST;

    logic [31:0] slot_base  [SLOT_COUNT];
    logic [15:0] slot_bytes [SLOT_COUNT];

    grant_t owed_grants [$];
    int     mismatches = 0;

    task_region_allocator #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request_size   (request_size),
        .done           (done),
        .region_address (region_address),
        .granted_size   (granted_size),
        .slot_index     (slot_index),
        .status         (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string detail);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", detail);
    endtask

    // first-fit placement with one ordered overlap pass (restarted once on a promotion), updates the slot table
    function automatic grant_t place_region(input logic [15:0] req);
        grant_t      g;
        int          free_slot;
        int          i;
        logic        restarted;
        logic [16:0] bytes;
        logic [32:0] cand;
        logic [32:0] lo;
        logic [32:0] hi;
        logic [32:0] tail;
        g = '0;
        free_slot = -1;
        for (i = SLOT_COUNT - 1; i >= 0; i--)
            if (slot_base[i] == 32'd0)
                free_slot = i;
        if (free_slot < 0)
        begin
            g.code = STATUS_FULL;
            return g;
        end
        if (req == 16'd0 || req > cfg_max_request)
        begin
            g.code = STATUS_BAD_SIZE;
            return g;
        end
        if (req <= SMALL_SIZE)
        begin
            bytes = {1'b0, SMALL_SIZE};
            cand = {1'b0, cfg_small_base};
        end
        else
        begin
            bytes = ({1'b0, req} + LARGE_MASK) & ~LARGE_MASK;
            if (bytes[16])
            begin
                g.code = STATUS_BAD_SIZE;
                return g;
            end
            cand = {1'b0, cfg_large_base};
        end
        i = 0;
        while (i < SLOT_COUNT)
        begin
            lo = {1'b0, slot_base[i]};
            hi = lo + {17'd0, slot_bytes[i]};
            tail = cand + {16'd0, bytes};
            restarted = 1'b0;
            if ((lo <= cand && cand < hi) || (lo <= tail && tail < hi))
            begin
                cand = hi;
                // small request pushed onto the large area is promoted
                if (bytes == {1'b0, SMALL_SIZE} && cand == {1'b0, cfg_large_base})
                begin
                    bytes = {1'b0, LARGE_UNIT};
                    cand = {1'b0, cfg_large_base};
                    i = 0;
                    restarted = 1'b1;
                end
            end
            if (!restarted)
                i++;
        end
        if (cand + {16'd0, bytes} <= {1'b0, cfg_heap_end})
        begin
            slot_base[free_slot] = cand[31:0];
            slot_bytes[free_slot] = bytes[15:0];
            g.addr = cand[31:0];
            g.bytes = bytes[15:0];
            g.slot = free_slot[5:0];
            g.code = STATUS_OK;
        end
        else
            g.code = STATUS_NO_ROOM;
        return g;
    endfunction

    // write a register, read it back, then update the shadow copy
    task automatic set_register(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == REG_MAX_REQUEST) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & keep) !== (value & keep))
            report_mismatch($sformatf("register %0d read %h, wrote %h", idx, prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SMALL_BASE:  cfg_small_base = value;
            REG_LARGE_BASE:  cfg_large_base = value;
            REG_HEAP_END:    cfg_heap_end = value;
            REG_MAX_REQUEST: cfg_max_request = value[15:0];
            default: ;
        endcase
    endtask

    // present one request, hold it until taken, then idle as drawn
    task automatic issue(input logic [15:0] req, input logic typed, input grant_t want,
                         input logic calm, input logic drain);
        grant_t g;
        int     gap;
        logic   hold;
        gap = calm ? 0 : $urandom_range(0, 3);
        hold = drain || (!calm && $urandom_range(0, 3) == 0);
        @(negedge clk);
        start <= 1'b1;
        request_size <= req;
        @(posedge clk);
        while (busy) @(posedge clk);
        g = place_region(req);
        owed_grants.push_back(typed ? want : g);
        if (hold || gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            if (hold)
                while (owed_grants.size() != 0) @(posedge clk);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (rst_n && done === 1'b1)
        begin
            got = {region_address, granted_size, slot_index, status};
            if (owed_grants.size() == 0)
                report_mismatch($sformatf("unexpected grant addr %h size %0d slot %0d status %0d",
                                          got.addr, got.bytes, got.slot, got.code));
            else
            begin
                want = owed_grants.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "addr %h/%h size %0d/%0d slot %0d/%0d status %0d/%0d (exp/act)",
                        want.addr, got.addr, want.bytes, got.bytes,
                        want.slot, got.slot, want.code, got.code));
            end
        end
    end

    initial
    begin
        int          n;
        int          phase;
        int          k;
        int          kind;
        logic [31:0] grid;
        logic [31:0] sb;
        logic [31:0] lb;
        logic [31:0] he;
        logic [15:0] mr;
        logic [15:0] req;
        logic        calm;
        for (n = 0; n < SLOT_COUNT; n++)
        begin
            slot_base[n] = '0;
            slot_bytes[n] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < PROBE_COUNT; n++)
            issue(PROBES[n].req, PROBES[n].typed, PROBES[n].want, 1'b0,
                  n == PROBE_COUNT - 1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            kind = (phase < 5) ? phase : $urandom_range(0, 4);
            grid = 32'h2000_0000 + 512 * $urandom_range(0, 64);
            mr = 16'($urandom_range(1, 65535));
            case (kind)
                0:
                begin
                    // heap ends inside the first small region: scan only
                    sb = grid;
                    lb = sb + 512 * $urandom_range(1, 3);
                    he = sb + $urandom_range(0, 511);
                end
                1:
                begin
                    sb = grid;
                    lb = sb + 512 * $urandom_range(1, 2);
                    he = lb + 1024 * $urandom_range(0, 1);
                    mr = MAX_REQUEST_RST;
                end
                2:
                begin
                    sb = grid;
                    lb = sb + 512;
                    he = lb + 1024 * $urandom_range(0, 1);
                    mr = (phase == 2) ? 16'd1 : 16'($urandom_range(1, 1024));
                end
                3:
                begin
                    // regions ending at or past the top of the 32-bit address space
                    sb = 32'hFFFF_FE00;
                    lb = 32'hFFFF_FC00;
                    he = 32'hFFFF_FFFF;
                    mr = 16'hFFFF;
                end
                default:
                begin
                    // grants at address zero leave the slot free
                    sb = 32'd0;
                    lb = 32'd0;
                    he = (phase == 4) ? 32'd0 : 32'd512;
                end
            endcase
            if (phase == PHASES - 1)
            begin
                // open heap so the table fills up
                sb = 32'h4000_0000;
                lb = 32'h4000_1000;
                he = 32'hFFFF_FFFF;
                mr = 16'hFFFF;
            end
            set_register(REG_SMALL_BASE, sb);
            set_register(REG_LARGE_BASE, lb);
            set_register(REG_HEAP_END, he);
            set_register(REG_MAX_REQUEST, {16'd0, mr});

            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: req = 16'($urandom_range(1, 512));
                    4, 5, 6:    req = 16'($urandom_range(513, (mr > 16'd513) ? mr : 513));
                    7:          req = 16'($urandom_range(0, 65535));
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0: req = 16'd0;
                            1: req = 16'd512;
                            2: req = 16'd513;
                            3: req = mr;
                            4: req = mr + 16'd1;
                            5: req = 16'hFFFF;
                            6: req = 16'd64512;
                            default: req = 16'd64513;
                        endcase
                    end
                endcase
                issue(req, 1'b0, '0, calm, k == PHASE_ITEMS - 1);
            end
        end

        while (owed_grants.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && owed_grants.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tra_pkg.sv
sv/task_region_allocator.sv
test/tb.sv
